### rtl/pfr_pkg.sv
// Package: types and constants of the page frame replacement unit.
`timescale 1ns / 1ps
`default_nettype none
package pfr_pkg;

    localparam int PAGE_W = 16;
    localparam int PROC_W = 3;
    localparam int TIME_W = 32;
    localparam int PICK_W = 16;
    localparam int FIDX_W = 4;
    localparam int CNT_W  = 32;
    localparam int CFG_W  = 5;
    localparam int POL_W  = 2;

    localparam logic [POL_W-1:0] POL_LRU  = 2'd0;
    localparam logic [POL_W-1:0] POL_FIFO = 2'd1;
    localparam logic [POL_W-1:0] POL_RAND = 2'd2;

    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_FRAMES = 1'b1;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [PROC_W-1:0] proc;
        logic [TIME_W-1:0] ltime;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_RMOD,
        S_RRD,
        S_RCAP,
        S_MOVE,
        S_FIN
    } t_state;

endpackage
`default_nettype wire

### rtl/page_frame_replacement_unit.sv
// Top level: page frame replacement unit with LRU, FIFO and random reorder.
`timescale 1ns / 1ps
`default_nettype none
//  channel | direction | handshake                      | payload
//  in      | input     | i_in_valid / o_in_ready        | page, process, time, pick
//  out     | output    | o_out_valid / i_out_ready      | hit, frame, eviction, faults
//  cfg     | input     | i_cfg_we                       | i_cfg_idx, i_cfg_data
//  Steps per item: accept, scan the entries in turn, then on an LRU hit or an eviction
//  shift the entries and write the moved entry, then finish.
//  Random reorder adds a bit-serial modulo of the pick and a fetch of the picked entry.
//  Reset: synchronous, active low; no clearing pass (fault counters use valid bits).
//  A finished result waits in the output register; the next transfer is taken meanwhile,
//  and its finish stalls until the waiting result is taken.
module page_frame_replacement_unit #(
    parameter int FRAMES    = 16,
    parameter int PROCESSES = 8
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire                              i_cfg_idx,
    input  wire [pfr_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire [pfr_pkg::PAGE_W-1:0]        i_page_number,
    input  wire [pfr_pkg::PROC_W-1:0]        i_process_id,
    input  wire [pfr_pkg::TIME_W-1:0]        i_ref_time,
    input  wire [pfr_pkg::PICK_W-1:0]        i_random_pick,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic                             o_hit,
    output logic [pfr_pkg::FIDX_W-1:0]       o_frame_index,
    output logic                             o_evicted,
    output logic [pfr_pkg::PAGE_W-1:0]       o_evicted_page,
    output logic [pfr_pkg::PROC_W-1:0]       o_evicted_process,
    output logic [pfr_pkg::TIME_W-1:0]       o_residency_time,
    output logic [pfr_pkg::CNT_W-1:0]        o_fault_count
);
    import pfr_pkg::*;

    localparam int IW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FW  = $clog2(FRAMES + 1);
    localparam int SW  = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int CW0 = (FW > CFG_W) ? FW : CFG_W;
    localparam int CW  = (CW0 > FIDX_W) ? CW0 : FIDX_W;
    localparam int EP_RST = ((FRAMES < 16) ? FRAMES : 16) - 1;

    t_state             r_state, n_state;
    logic [POL_W-1:0]   r_policy;
    logic [CFG_W-1:0]   r_fcount;
    logic [FW-1:0]      r_occ, n_occ;
    logic [IW-1:0]      r_ep, n_ep;
    logic [PAGE_W-1:0]  r_page, n_page;
    logic [PROC_W-1:0]  r_proc, n_proc;
    logic [TIME_W-1:0]  r_time, n_time;
    logic [PICK_W-1:0]  r_pick, n_pick;
    logic [SW-1:0]      r_slot, n_slot;
    logic [IW-1:0]      r_sk, n_sk;
    t_entry             r_front, n_front;
    t_entry             r_hold, n_hold;
    logic [IW-1:0]      r_cur, n_cur;
    logic [IW-1:0]      r_to, n_to;
    logic               r_up, n_up;
    logic [FW-1:0]      r_rem, n_rem;
    logic [3:0]         r_bit, n_bit;
    logic               r_fault, n_fault;
    logic               r_hit, n_hit;
    logic [FIDX_W-1:0]  r_fidx, n_fidx;
    logic               r_ev, n_ev;
    logic [PAGE_W-1:0]  r_evpg, n_evpg;
    logic [PROC_W-1:0]  r_evpr, n_evpr;
    logic [TIME_W-1:0]  r_res, n_res;
    logic               r_ov, n_ov;
    logic               load_out;
    logic [CNT_W-1:0]   n_cnt;

    t_entry             q_mem [FRAMES];
    t_entry             q_rd;
    logic [IW-1:0]      q_ra;
    logic               q_we;
    logic [IW-1:0]      q_wa;
    t_entry             q_wd;

    logic [CNT_W-1:0]   f_mem [PROCESSES];
    logic [CNT_W-1:0]   f_rd;
    logic [PROCESSES-1:0] r_fvld;
    logic               f_we;

    logic [CW-1:0]      fc_x, frames_x;
    logic [FW-1:0]      frames;
    logic [6:0]         slot_x;
    t_entry             front;
    logic               match, last;
    logic [FW:0]        rem_sh;

    assign fc_x     = CW'(r_fcount);
    assign frames_x = (fc_x == '0) ? CW'(1) : ((fc_x > CW'(FRAMES)) ? CW'(FRAMES) : fc_x);
    assign frames   = frames_x[FW-1:0];
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;

    always_comb begin
        slot_x = 7'(i_process_id);
        for (int k = 0; k < 8; k++) begin
            if (slot_x >= 7'(PROCESSES)) begin
                slot_x = slot_x - 7'(PROCESSES);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            q_mem[q_wa] <= q_wd;
        end
        q_rd <= q_mem[q_ra];
        if (f_we) begin
            f_mem[r_slot] <= n_cnt;
        end
        f_rd <= f_mem[r_slot];
    end

    always_comb begin
        n_state = r_state;
        n_occ = r_occ;     n_ep = r_ep;       n_page = r_page;  n_proc = r_proc;
        n_time = r_time;   n_pick = r_pick;   n_slot = r_slot;  n_sk = r_sk;
        n_front = r_front; n_hold = r_hold;   n_cur = r_cur;    n_to = r_to;
        n_up = r_up;       n_rem = r_rem;     n_bit = r_bit;    n_fault = r_fault;
        n_hit = r_hit;     n_fidx = r_fidx;   n_ev = r_ev;      n_evpg = r_evpg;
        n_evpr = r_evpr;   n_res = r_res;
        n_ov = r_ov & ~i_out_ready;
        load_out = 1'b0;
        q_ra = '0;
        q_we = 1'b0;
        q_wa = r_cur;
        q_wd = q_rd;
        f_we = 1'b0;
        n_cnt = (r_fvld[r_slot] ? f_rd : '0) + CNT_W'(r_fault);
        front = (r_sk == '0) ? q_rd : r_front;
        match = (FW'(r_sk) < r_occ) && (q_rd.page == r_page) && (q_rd.proc == r_proc);
        last = (r_occ == '0) || (FW'(r_sk) == r_occ - FW'(1));
        rem_sh = {r_rem, r_pick[PICK_W-1]};
        if (rem_sh >= {1'b0, r_occ}) begin
            rem_sh = rem_sh - {1'b0, r_occ};
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_page = i_page_number;
                    n_proc = i_process_id;
                    n_time = i_ref_time;
                    n_pick = i_random_pick;
                    n_slot = slot_x[SW-1:0];
                    n_sk = '0;
                    n_hit = 1'b0; n_ev = 1'b0; n_evpg = '0; n_evpr = '0;
                    n_res = '0; n_fault = 1'b0;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (r_sk == '0) begin
                    n_front = q_rd;
                end
                if (match) begin
                    n_hit = 1'b1;
                    n_fidx = FIDX_W'(frames_x - CW'(r_sk) - CW'(1));
                    case (r_policy)
                        POL_LRU: begin
                            n_hold = q_rd;
                            n_cur = r_sk;
                            n_to = IW'(r_occ - FW'(1));
                            n_up = 1'b1;
                            q_ra = r_sk + IW'(1);
                            n_state = S_MOVE;
                        end
                        POL_RAND: begin
                            n_rem = '0;
                            n_bit = '0;
                            n_state = S_RMOD;
                        end
                        default: n_state = S_FIN;
                    endcase
                end else if (last) begin
                    n_fault = 1'b1;
                    if (r_occ < frames) begin
                        q_we = 1'b1;
                        q_wa = IW'(r_occ);
                        q_wd = '{page: r_page, proc: r_proc, ltime: r_time};
                        n_occ = r_occ + FW'(1);
                        n_fidx = FIDX_W'(frames_x - CW'(r_occ) - CW'(1));
                        n_state = S_FIN;
                    end else begin
                        n_ev = 1'b1;
                        n_evpg = front.page;
                        n_evpr = front.proc;
                        n_res = r_time - front.ltime;
                        n_fidx = FIDX_W'(r_ep);
                        n_ep = (r_ep != '0) ? r_ep - IW'(1) : IW'(frames - FW'(1));
                        n_hold = '{page: r_page, proc: r_proc, ltime: r_time};
                        n_cur = '0;
                        n_to = IW'(r_occ - FW'(1));
                        n_up = 1'b1;
                        q_ra = IW'(1);
                        n_state = S_MOVE;
                    end
                end else begin
                    n_sk = r_sk + IW'(1);
                    q_ra = r_sk + IW'(1);
                end
            end
            S_RMOD: begin
                n_rem = rem_sh[FW-1:0];
                n_pick = r_pick << 1;
                n_bit = r_bit + 4'd1;
                if (r_bit == 4'd15) begin
                    n_state = S_RRD;
                end
            end
            S_RRD: begin
                q_ra = IW'(r_rem);
                n_state = S_RCAP;
            end
            S_RCAP: begin
                n_hold = q_rd;
                n_cur = IW'(r_rem);
                n_to = '0;
                n_up = 1'b0;
                q_ra = IW'(r_rem) - IW'(1);
                n_state = S_MOVE;
            end
            S_MOVE: begin
                q_we = 1'b1;
                if (r_cur == r_to) begin
                    q_wa = r_to;
                    q_wd = r_hold;
                    n_state = S_FIN;
                end else begin
                    q_wa = r_cur;
                    q_wd = q_rd;
                    n_cur = r_up ? r_cur + IW'(1) : r_cur - IW'(1);
                    q_ra = r_up ? r_cur + IW'(2) : r_cur - IW'(2);
                end
            end
            S_FIN: begin
                if (!r_ov || i_out_ready) begin
                    f_we = r_fault;
                    load_out = 1'b1;
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_policy <= POL_LRU;
            r_fcount <= CFG_W'(16);
            r_occ    <= '0;
            r_ep     <= IW'(EP_RST);
            r_ov     <= 1'b0;
            r_fvld   <= '0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_ep    <= n_ep;
            r_ov    <= n_ov;
            if (f_we) begin
                r_fvld[r_slot] <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POLICY: r_policy <= i_cfg_data[POL_W-1:0];
                    CFG_FRAMES: r_fcount <= i_cfg_data;
                    default:    r_policy <= r_policy;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_page <= n_page;   r_proc <= n_proc;   r_time <= n_time;   r_pick <= n_pick;
        r_slot <= n_slot;   r_sk <= n_sk;       r_front <= n_front; r_hold <= n_hold;
        r_cur <= n_cur;     r_to <= n_to;       r_up <= n_up;       r_rem <= n_rem;
        r_bit <= n_bit;     r_fault <= n_fault; r_hit <= n_hit;     r_fidx <= n_fidx;
        r_ev <= n_ev;       r_evpg <= n_evpg;   r_evpr <= n_evpr;   r_res <= n_res;
        if (load_out) begin
            o_hit             <= r_hit;
            o_frame_index     <= r_fidx;
            o_evicted         <= r_ev;
            o_evicted_page    <= r_evpg;
            o_evicted_process <= r_evpr;
            o_residency_time  <= r_res;
            o_fault_count     <= n_cnt;
        end
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= FW'(FRAMES))
        else $error("occupancy beyond frame store");

    a_accept_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_SEARCH))
        else $error("accepted transfer did not start a search");

    a_move_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE) |-> (FW'(r_cur) < r_occ && FW'(r_to) < r_occ))
        else $error("queue move outside occupied entries");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> ($past(r_state) == S_FIN))
        else $error("result raised outside finish");

endmodule
`default_nettype wire
